@@ design/tle_pkg.sv @@
// ----------------------------------------------------------------------------
// tle_pkg
// Types and constants shared by the terminal line editor modules.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam logic [7:0] KEY_LF     = 8'h0A;
   localparam logic [7:0] KEY_CR     = 8'h0D;
   localparam logic [7:0] KEY_SOH    = 8'h01;
   localparam logic [7:0] KEY_ETX    = 8'h03;
   localparam logic [7:0] KEY_EOT    = 8'h04;
   localparam logic [7:0] KEY_ENQ    = 8'h05;
   localparam logic [7:0] KEY_BS     = 8'h08;
   localparam logic [7:0] KEY_VT     = 8'h0B;
   localparam logic [7:0] KEY_FF     = 8'h0C;
   localparam logic [7:0] KEY_NAK    = 8'h15;
   localparam logic [7:0] KEY_ETB    = 8'h17;
   localparam logic [7:0] KEY_ESC    = 8'h1B;
   localparam logic [7:0] KEY_DEL    = 8'h7F;
   localparam logic [7:0] KEY_LBRACK = 8'h5B;
   localparam logic [7:0] KEY_SS3_O  = 8'h4F;
   localparam logic [7:0] KEY_TILDE  = 8'h7E;
   localparam logic [7:0] KEY_FIN_RIGHT = 8'h43;
   localparam logic [7:0] KEY_FIN_LEFT  = 8'h44;
   localparam logic [7:0] KEY_FIN_HOME  = 8'h48;
   localparam logic [7:0] KEY_FIN_END   = 8'h46;
   localparam logic [6:0] SEQ_HOME1  = 7'd1;
   localparam logic [6:0] SEQ_DELETE = 7'd3;
   localparam logic [6:0] SEQ_END1   = 7'd4;
   localparam logic [6:0] SEQ_HOME2  = 7'd15;
   localparam logic [6:0] SEQ_END2   = 7'd17;

   typedef enum logic [2:0] {
      KIND_STATUS = 3'd0,
      KIND_BYTE   = 3'd1,
      KIND_EMPTY  = 3'd2,
      KIND_ABORT  = 3'd3,
      KIND_EOF    = 3'd4,
      KIND_CLEAR  = 3'd5,
      KIND_FULL   = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_ESC  = 3'd1,
      PH_CSI  = 3'd2,
      PH_NUM1 = 3'd3,
      PH_NUM2 = 3'd4,
      PH_SS3  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_LEFT  = 3'd1,
      ACT_RIGHT = 3'd2,
      ACT_HOME  = 3'd3,
      ACT_END   = 3'd4,
      ACT_DEL   = 3'd5
   } act_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_SHIFT  = 3'd1,
      ST_SCAN   = 3'd2,
      ST_EMIT   = 3'd3,
      ST_RESULT = 3'd4
   } state_type;

   // chain command to every cell
   typedef enum logic [1:0] {
      CH_HOLD  = 2'd0,
      CH_LEFT  = 2'd1,   // take neighbor above (cut)
      CH_RIGHT = 2'd2,   // take neighbor below (insert)
      CH_ROT   = 2'd3    // rotate toward index zero
   } chain_cmd_type;

   typedef struct packed {
      chain_cmd_type cmd;
      logic [6:0]    lo;     // cells at or above lo take part
      logic          put;    // write put_byte into cell lo
      logic [7:0]    put_byte;
   } chain_ctl_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
   endfunction

endpackage

@@ design/tle_cell.sv @@
// ----------------------------------------------------------------------------
// tle_cell
// One byte of the line; shifts with its neighbors under a shared command.
// ----------------------------------------------------------------------------
module tle_cell (
   input  logic                   clock,
   input  tle_pkg::chain_ctl_type ctl,
   input  logic                   active,
   input  logic                   put_here,
   input  logic [7:0]             from_below,
   input  logic [7:0]             from_above,
   input  logic [7:0]             from_wrap,
   input  logic                   is_top,
   output logic [7:0]             data
);
   import tle_pkg::*;

   logic [7:0] data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (put_here) begin
         data_in = ctl.put_byte;
      end else if (active) begin
         case (ctl.cmd)
            CH_LEFT:  data_in = from_above;
            CH_RIGHT: data_in = from_below;
            CH_ROT:   data_in = is_top ? from_wrap : from_above;
            default:  data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

@@ design/tle_chain.sv @@
// ----------------------------------------------------------------------------
// tle_chain
// Row of line cells; cell zero is the line start.
// ----------------------------------------------------------------------------
module tle_chain #(
   parameter int LINE_CAP = 64
) (
   input  logic                   clock,
   input  tle_pkg::chain_ctl_type ctl,
   output logic [LINE_CAP*8-1:0]  cells
);
   import tle_pkg::*;

   logic [7:0] q [LINE_CAP];

   for (genvar g = 0; g < LINE_CAP; g++) begin : g_cell
      logic [7:0] below, above;
      if (g == 0) begin : g_b0
         assign below = 8'h00;
      end else begin : g_b
         assign below = q[g-1];
      end
      if (g == LINE_CAP - 1) begin : g_a0
         assign above = 8'h00;
      end else begin : g_a
         assign above = q[g+1];
      end
      tle_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .active     (7'(g) >= ctl.lo),
         .put_here   (ctl.put && 7'(g) == ctl.lo),
         .from_below (below),
         .from_above (above),
         .from_wrap  (q[0]),
         .is_top     (g == LINE_CAP - 1),
         .data       (q[g])
      );
      assign cells[g*8 +: 8] = q[g];
   end
endmodule

@@ design/terminal_line_editor.sv @@
// ----------------------------------------------------------------------------
// terminal_line_editor
// VT100 / Emacs key line editor built on a shifting row of byte cells.
// ----------------------------------------------------------------------------
// Each key is registered on acceptance and decoded in ST_RESULT, which registers
// the beat of a simple key or an insert; a cut first shifts the cells left one
// byte at a time in ST_SHIFT, and Ctrl-W first scans back in ST_SCAN. Enter then
// emits one beat per cycle while the receiver does not stall, up to LINE_CAP beats.
// One key at a time: a new key is taken only after the last key's beats are taken.
// Reset clears length, cursor and escape state; cell contents are undefined.
module terminal_line_editor #(
   parameter int LINE_CAP = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] key_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [2:0] kind, [10:3] line_char,
                                    // [17:11] line_length, [24:18] cursor_pos,
                                    // [31:25] zero
   output logic        rsp_tlast,
   output logic        rsp_tuser    // redraw
);
   import tle_pkg::*;

   localparam logic [6:0] CAP = 7'(LINE_CAP);

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [6:0]    len_ff, len_in, cur_ff, cur_in, seq_ff, seq_in;
   logic [6:0]    cnt_ff, cnt_in, p_ff, p_in;
   logic          wsp_ff, wsp_in;
   logic [7:0]    key_ff, key_in;
   kind_type      okind_ff, okind_in;
   logic [7:0]    ochar_ff, ochar_in;
   logic          ord_ff, ord_in, olast_ff, olast_in, ov_ff, ov_in;
   logic [6:0]    olen_ff, olen_in, ocur_ff, ocur_in;
   chain_ctl_type ctl;
   logic [LINE_CAP*8-1:0] cells;
   logic [7:0]    c0, cp, cpm;

   tle_chain #(.LINE_CAP(LINE_CAP)) u_chain (.clock(clock), .ctl(ctl), .cells(cells));

   assign c0  = cells[7:0];
   assign cp  = cells[p_ff[$clog2(LINE_CAP)-1:0]*8 +: 8];
   assign cpm = cells[(p_ff[$clog2(LINE_CAP)-1:0] - 1'b1)*8 +: 8];

   // decode one key; cuts shift one place per cycle, counted in cnt
   always_comb begin
      logic [7:0] b;
      logic dig;
      act_type act;
      b = key_ff;
      dig = b >= 8'h30 && b <= 8'h39;
      act = ACT_NONE;
      state_in = state_ff; phase_in = phase_ff; len_in = len_ff; cur_in = cur_ff;
      seq_in = seq_ff; cnt_in = cnt_ff; p_in = p_ff; wsp_in = wsp_ff;
      key_in = key_ff;
      okind_in = okind_ff; ochar_in = ochar_ff; ord_in = ord_ff;
      olast_in = olast_ff; ov_in = ov_ff; olen_in = olen_ff; ocur_in = ocur_ff;
      ctl = '{cmd: CH_HOLD, lo: 7'd0, put: 1'b0, put_byte: 8'h00};
      req_tready = 1'b0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !ov_ff;
            if (req_tvalid && !ov_ff) begin
               key_in = req_tdata;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            okind_in = KIND_STATUS; ochar_in = 8'h00; ord_in = 1'b0; olast_in = 1'b1;
            state_in = ST_IDLE;
            if (phase_ff != PH_IDLE) begin
               phase_in = PH_IDLE;
               case (phase_ff)
                  PH_ESC: begin
                     if (b == KEY_LBRACK) phase_in = PH_CSI;
                     else if (b == KEY_SS3_O) phase_in = PH_SS3;
                  end
                  PH_CSI, PH_SS3: begin
                     if (phase_ff == PH_CSI && dig) begin
                        seq_in = {3'd0, b[3:0]}; phase_in = PH_NUM1;
                     end else if (b == KEY_FIN_RIGHT) act = ACT_RIGHT;
                     else if (b == KEY_FIN_LEFT) act = ACT_LEFT;
                     else if (b == KEY_FIN_HOME) act = ACT_HOME;
                     else if (b == KEY_FIN_END) act = ACT_END;
                  end
                  PH_NUM1: begin
                     if (b == KEY_TILDE) begin
                        if (seq_ff == SEQ_HOME1) act = ACT_HOME;
                        else if (seq_ff == SEQ_DELETE) act = ACT_DEL;
                        else if (seq_ff == SEQ_END1) act = ACT_END;
                     end else if (dig) begin
                        seq_in = 7'((seq_ff * 7'd10) + {3'd0, b[3:0]});
                        phase_in = PH_NUM2;
                     end
                  end
                  PH_NUM2: begin
                     if (b == KEY_TILDE) begin
                        if (seq_ff == SEQ_HOME2) act = ACT_HOME;
                        else if (seq_ff == SEQ_END2) act = ACT_END;
                     end
                  end
                  default: ;
               endcase
               case (act)
                  ACT_LEFT: begin
                     ord_in = 1'b1; if (cur_ff != 7'd0) cur_in = cur_ff - 7'd1;
                  end
                  ACT_RIGHT: begin
                     ord_in = 1'b1; if (cur_ff < len_ff) cur_in = cur_ff + 7'd1;
                  end
                  ACT_HOME: begin ord_in = 1'b1; cur_in = 7'd0; end
                  ACT_END: begin ord_in = 1'b1; cur_in = len_ff; end
                  ACT_DEL: if (cur_ff < len_ff) begin
                     ord_in = 1'b1; p_in = cur_ff; cnt_in = 7'd1; state_in = ST_SHIFT;
                  end
                  default: ;
               endcase
               if (state_in == ST_IDLE) begin
                  ov_in = 1'b1; olen_in = len_in; ocur_in = cur_in;
               end
            end else if (b == KEY_LF || b == KEY_CR) begin
               if (len_ff == 7'd0) begin
                  okind_in = KIND_EMPTY; ov_in = 1'b1; olen_in = 7'd0; ocur_in = 7'd0;
               end else begin
                  cnt_in = len_ff; len_in = 7'd0; cur_in = 7'd0; state_in = ST_EMIT;
               end
            end else if (b == KEY_ETX) begin
               len_in = 7'd0; cur_in = 7'd0; okind_in = KIND_ABORT; ov_in = 1'b1;
               olen_in = 7'd0; ocur_in = 7'd0;
            end else if (b == KEY_BS || b == KEY_DEL) begin
               if (cur_ff != 7'd0) begin
                  ord_in = 1'b1; p_in = cur_ff - 7'd1; cnt_in = 7'd1; state_in = ST_SHIFT;
               end else begin
                  ov_in = 1'b1; olen_in = len_ff; ocur_in = cur_ff;
               end
            end else if (b == KEY_NAK) begin
               ord_in = 1'b1;
               if (cur_ff != 7'd0) begin
                  p_in = 7'd0; cnt_in = cur_ff; state_in = ST_SHIFT;
               end else begin
                  ov_in = 1'b1; olen_in = len_ff; ocur_in = cur_ff;
               end
            end else if (b == KEY_ETB) begin
               ord_in = 1'b1;
               if (cur_ff != 7'd0) begin
                  p_in = cur_ff - 7'd1; wsp_in = 1'b1; state_in = ST_SCAN;
               end else begin
                  ov_in = 1'b1; olen_in = len_ff; ocur_in = cur_ff;
               end
            end else if (b >= 8'h20 && b <= 8'h7E) begin
               if (len_ff >= CAP) begin
                  okind_in = KIND_FULL; ov_in = 1'b1; olen_in = len_ff; ocur_in = cur_ff;
               end else begin
                  ctl = '{cmd: CH_RIGHT, lo: cur_ff, put: 1'b1, put_byte: b};
                  cur_in = cur_ff + 7'd1; len_in = len_ff + 7'd1; ord_in = 1'b1;
                  ov_in = 1'b1; olen_in = len_in; ocur_in = cur_in;
               end
            end else begin
               case (b)
                  KEY_EOT: if (len_ff == 7'd0) okind_in = KIND_EOF;
                  KEY_ESC: phase_in = PH_ESC;
                  KEY_SOH: begin ord_in = 1'b1; cur_in = 7'd0; end
                  KEY_ENQ: begin ord_in = 1'b1; cur_in = len_ff; end
                  KEY_VT:  begin ord_in = 1'b1; len_in = cur_ff; end
                  KEY_FF:  begin ord_in = 1'b1; okind_in = KIND_CLEAR; end
                  default: ;
               endcase
               ov_in = 1'b1; olen_in = len_in; ocur_in = cur_in;
            end
         end
         ST_SCAN: begin
            // skip spaces back, then the word back, one byte per cycle
            if (p_ff == 7'd0) begin
               cnt_in = cur_ff; state_in = ST_SHIFT;
            end else if (wsp_ff) begin
               if (is_space(cp)) p_in = p_ff - 7'd1;
               else wsp_in = 1'b0;
            end else begin
               if (!is_space(cpm)) p_in = p_ff - 7'd1;
               else begin cnt_in = cur_ff - p_ff; state_in = ST_SHIFT; end
            end
         end
         ST_SHIFT: begin
            if (cnt_ff != 7'd0) begin
               ctl = '{cmd: CH_LEFT, lo: p_ff, put: 1'b0, put_byte: 8'h00};
               cnt_in = cnt_ff - 7'd1; len_in = len_ff - 7'd1;
            end else begin
               cur_in = p_ff; state_in = ST_IDLE;
               ov_in = 1'b1; olen_in = len_ff; ocur_in = p_ff;
            end
         end
         ST_EMIT: begin
            if (!ov_ff || rsp_tready) begin
               ctl = '{cmd: CH_ROT, lo: 7'd0, put: 1'b0, put_byte: 8'h00};
               okind_in = KIND_BYTE; ochar_in = c0; ord_in = 1'b0;
               olast_in = (cnt_ff == 7'd1); ov_in = 1'b1; olen_in = 7'd0; ocur_in = 7'd0;
               cnt_in = cnt_ff - 7'd1;
               if (cnt_ff == 7'd1) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; phase_ff <= PH_IDLE; len_ff <= 7'd0; cur_ff <= 7'd0;
         seq_ff <= 7'd0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; len_ff <= len_in; cur_ff <= cur_in;
         seq_ff <= seq_in; ov_ff <= ov_in;
      end
      cnt_ff <= cnt_in; p_ff <= p_in; wsp_ff <= wsp_in; key_ff <= key_in;
      okind_ff <= okind_in; ochar_ff <= ochar_in; ord_ff <= ord_in;
      olast_ff <= olast_in; olen_ff <= olen_in; ocur_ff <= ocur_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {7'd0, ocur_ff, olen_ff, ochar_ff, okind_ff};
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ord_ff;

   a_len_cap: assert property (@(posedge clock) disable iff (reset) len_ff <= CAP)
      else $error("line length above capacity");
   a_cur_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> cur_ff <= len_ff) else $error("cursor past line end");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE && !ov_ff) else $error("ready while busy");
endmodule

@@ sim/terminal_line_editor_tb.sv @@
// ----------------------------------------------------------------------------
// terminal_line_editor_tb
// Self-checking bench for the terminal line editor. A queue of key bytes feeds
// a driver; each accepted key runs through a behavioral line editor that
// queues the expected response beats. A monitor compares every response beat
// field by field. Four phases vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_line_editor_tb;
   import tle_pkg::*;

   localparam int LINE_CAP  = 64;
   localparam int MAX_CYCLE = 3000000;

   typedef struct {
      kind_type   kind;
      logic [7:0] line_char;
      logic [6:0] line_length;
      logic [6:0] cursor_pos;
      logic       redraw;
      logic       last;
   } edit_beat_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   terminal_line_editor #(.LINE_CAP(LINE_CAP)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   logic [7:0]     pending_keys[$];
   edit_beat_type  expected_beats[$];
   int          error_count = 0;
   int          sender_idle = 0;
   int          receiver_stall = 0;
   int          cycle_count = 0;
   int          keys_queued = 0;
   logic        key_taken = 1'b0;

   logic [7:0]  line_buf[LINE_CAP];
   int          line_len = 0;
   int          cur = 0;
   phase_type   esc_phase = PH_IDLE;
   int          esc_code = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic blank(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   task automatic push_beat(input kind_type k, input logic [7:0] ch, input logic rd,
                            input logic lst);
      edit_beat_type e;
      e.kind = k;
      e.line_char = ch;
      e.line_length = 7'(line_len);
      e.cursor_pos = 7'(cur);
      e.redraw = rd;
      e.last = lst;
      expected_beats.push_back(e);
   endtask

   task automatic remove_span(input int from, input int upto);
      int n;
      n = upto - from;
      for (int i = upto; i < line_len; i++) line_buf[i - n] = line_buf[i];
      line_len -= n;
      cur = from;
   endtask

   function automatic act_type letter_move(input logic [7:0] b);
      case (b)
         KEY_FIN_RIGHT: return ACT_RIGHT;
         KEY_FIN_LEFT:  return ACT_LEFT;
         KEY_FIN_HOME:  return ACT_HOME;
         KEY_FIN_END:   return ACT_END;
         default:       return ACT_NONE;
      endcase
   endfunction

   task automatic apply_move(input act_type mv, output logic rd);
      rd = 1'b1;
      case (mv)
         ACT_LEFT:  if (cur > 0) cur--;
         ACT_RIGHT: if (cur < line_len) cur++;
         ACT_HOME:  cur = 0;
         ACT_END:   cur = line_len;
         ACT_DEL:   if (cur < line_len) remove_span(cur, cur + 1); else rd = 1'b0;
         default:   rd = 1'b0;
      endcase
   endtask

   task automatic edit_key(input logic [7:0] b);
      kind_type   k;
      logic       rd;
      logic       dig;
      phase_type  ph;
      act_type    mv;
      int         n;
      int         p;
      k = KIND_STATUS;
      rd = 1'b0;
      mv = ACT_NONE;
      dig = b >= "0" && b <= "9";
      if (esc_phase != PH_IDLE) begin
         ph = esc_phase;
         esc_phase = PH_IDLE;
         case (ph)
            PH_ESC: begin
               if (b == KEY_LBRACK) esc_phase = PH_CSI;
               else if (b == KEY_SS3_O) esc_phase = PH_SS3;
            end
            PH_CSI: begin
               if (dig) begin
                  esc_code = b - "0";
                  esc_phase = PH_NUM1;
               end else mv = letter_move(b);
            end
            PH_SS3: mv = letter_move(b);
            PH_NUM1: begin
               if (b == KEY_TILDE) begin
                  if (esc_code == SEQ_HOME1) mv = ACT_HOME;
                  else if (esc_code == SEQ_DELETE) mv = ACT_DEL;
                  else if (esc_code == SEQ_END1) mv = ACT_END;
               end else if (dig) begin
                  esc_code = (esc_code * 10 + (b - "0")) & 8'h7F;
                  esc_phase = PH_NUM2;
               end
            end
            PH_NUM2: begin
               if (b == KEY_TILDE) begin
                  if (esc_code == SEQ_HOME2) mv = ACT_HOME;
                  else if (esc_code == SEQ_END2) mv = ACT_END;
               end
            end
            default: ;
         endcase
         apply_move(mv, rd);
      end else if (b == KEY_LF || b == KEY_CR) begin
         n = line_len;
         line_len = 0;
         cur = 0;
         if (n == 0) push_beat(KIND_EMPTY, 8'h00, 1'b0, 1'b1);
         else for (int i = 0; i < n; i++)
            push_beat(KIND_BYTE, line_buf[i], 1'b0, i == n - 1);
         return;
      end else if (b == KEY_ETX) begin
         line_len = 0;
         cur = 0;
         k = KIND_ABORT;
      end else if (b == KEY_EOT) begin
         if (line_len == 0) k = KIND_EOF;
      end else if (b == KEY_BS || b == KEY_DEL) begin
         if (cur > 0) begin
            remove_span(cur - 1, cur);
            rd = 1'b1;
         end
      end else if (b == KEY_ESC) begin
         esc_phase = PH_ESC;
      end else if (b == KEY_SOH) begin
         apply_move(ACT_HOME, rd);
      end else if (b == KEY_ENQ) begin
         apply_move(ACT_END, rd);
      end else if (b == KEY_VT) begin
         line_len = cur;
         rd = 1'b1;
      end else if (b == KEY_NAK) begin
         if (cur > 0) remove_span(0, cur);
         rd = 1'b1;
      end else if (b == KEY_ETB) begin
         if (cur > 0) begin
            p = cur - 1;
            while (p > 0 && blank(line_buf[p])) p--;
            while (p > 0 && !blank(line_buf[p - 1])) p--;
            remove_span(p, cur);
         end
         rd = 1'b1;
      end else if (b == KEY_FF) begin
         k = KIND_CLEAR;
         rd = 1'b1;
      end else if (b >= 8'h20 && b <= 8'h7E) begin
         if (line_len >= LINE_CAP) k = KIND_FULL;
         else begin
            for (int i = line_len; i > cur; i--) line_buf[i] = line_buf[i - 1];
            line_buf[cur] = b;
            cur++;
            line_len++;
            rd = 1'b1;
         end
      end
      push_beat(k, 8'h00, rd, 1'b1);
   endtask

   task automatic queue_key(input logic [7:0] b);
      pending_keys.push_back(b);
      keys_queued++;
   endtask

   task automatic queue_seq(input string s);
      for (int i = 0; i < s.len(); i++) queue_key(s[i]);
   endtask

   task automatic queue_escape();
      queue_key(KEY_ESC);
      case ($urandom_range(0, 15))
         0:  queue_seq("[C");
         1:  queue_seq("[D");
         2:  queue_seq("[H");
         3:  queue_seq("[F");
         4:  queue_seq("OC");
         5:  queue_seq("OD");
         6:  queue_seq("OH");
         7:  queue_seq("OF");
         8:  queue_seq("[1~");
         9:  queue_seq("[3~");
         10: queue_seq("[4~");
         11: queue_seq("[15~");
         12: queue_seq("[17~");
         13: queue_seq("[A");
         14: begin
            queue_key(KEY_LBRACK);
            queue_key(8'($urandom_range(0, 255)));
            queue_key(8'($urandom_range(0, 255)));
         end
         default: queue_key(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic queue_random_stretch();
      logic [7:0] ctl[9];
      int         n;
      ctl = '{KEY_SOH, KEY_ENQ, KEY_VT, KEY_NAK, KEY_ETB,
              KEY_BS, KEY_DEL, KEY_ETX, KEY_EOT};
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5: begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               queue_key($urandom_range(0, 4) == 0 ? 8'h20 : 8'($urandom_range(8'h21, 8'h7E)));
         end
         6, 7, 8, 9: queue_escape();
         10, 11, 12: queue_key(ctl[$urandom_range(0, 8)]);
         13, 14: queue_key($urandom_range(0, 1) ? KEY_CR : KEY_LF);
         15: begin
            n = $urandom_range(LINE_CAP - 4, LINE_CAP + 2);
            for (int i = 0; i < n; i++) queue_key(8'($urandom_range(8'h20, 8'h7E)));
         end
         default: queue_key(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      sender_idle = idle_pct;
      receiver_stall = stall_pct;
      keys_queued = 0;
      while (keys_queued < count) queue_random_stretch();
      wait (pending_keys.size() == 0 && expected_beats.size() == 0 && !req_tvalid);
   endtask

   // driver: update inputs on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall);
         if (req_tvalid && !key_taken) begin
            // hold the beat until accepted
         end else if (pending_keys.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
            req_tdata <= pending_keys.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: sample on the rising edge
   always @(posedge clock) begin
      edit_beat_type e;
      cycle_count <= cycle_count + 1;
      key_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) edit_key(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            e = expected_beats.pop_front();
            if (rsp_tdata[2:0] != e.kind) begin
               $error("kind: expected %0d, actual %0d", e.kind, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[10:3] != e.line_char) begin
               $error("line_char: expected %h, actual %h", e.line_char, rsp_tdata[10:3]);
               error_count++;
            end
            if (rsp_tdata[17:11] != e.line_length) begin
               $error("line_length: expected %0d, actual %0d", e.line_length,
                      rsp_tdata[17:11]);
               error_count++;
            end
            if (rsp_tdata[24:18] != e.cursor_pos) begin
               $error("cursor_pos: expected %0d, actual %0d", e.cursor_pos,
                      rsp_tdata[24:18]);
               error_count++;
            end
            if (rsp_tuser != e.redraw) begin
               $error("redraw: expected %0d, actual %0d", e.redraw, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast != e.last) begin
               $error("last: expected %0d, actual %0d", e.last, rsp_tlast);
               error_count++;
            end
         end
      end
      if (cycle_count >= MAX_CYCLE) begin
         $display("terminal_line_editor_tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      rsp_tready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty enter, eof, edits, CSI and SS3 sequence forms, kills, enter
      queue_key(KEY_CR);
      queue_key(KEY_EOT);
      queue_key(KEY_BS);
      queue_seq("ab cd");
      queue_key(KEY_EOT);
      queue_key(KEY_SOH);
      queue_key(KEY_ESC); queue_seq("[3~");
      queue_key(KEY_ESC); queue_seq("[4~");
      queue_key(KEY_ESC); queue_seq("[3~");
      queue_key(KEY_ESC); queue_seq("OD");
      queue_key(KEY_ESC); queue_seq("[15~");
      queue_key(KEY_ESC); queue_seq("[17~");
      queue_key(KEY_ESC); queue_key(KEY_CR);
      queue_key(8'h7E); queue_key(8'h20); queue_key(8'h09); queue_key(8'hFF); queue_key(8'h80);
      queue_key(KEY_ETB);
      queue_key(KEY_FF);
      queue_key(KEY_ENQ);
      queue_key(KEY_DEL);
      queue_key(KEY_VT);
      queue_key(KEY_NAK);
      queue_key(KEY_LF);
      queue_key(KEY_ETX);
      wait (pending_keys.size() == 0 && expected_beats.size() == 0 && !req_tvalid);

      run_phase(0, 0, 28);
      run_phase(53, 0, 28);
      run_phase(0, 53, 28);
      run_phase(8, 8, 28);

      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_beats.size() == 0)
         $display("terminal_line_editor_tb: done, clean");
      else
         $display("terminal_line_editor_tb: done, errors");
      $finish;
   end

endmodule

@@ filelist.f @@
design/tle_pkg.sv
design/tle_cell.sv
design/tle_chain.sv
design/terminal_line_editor.sv
sim/terminal_line_editor_tb.sv
